/* hdl/dnsa_pkg.sv */
// dnsa_pkg: shared types, constants and the answer record table of the
// dns a-query responder. No dependencies.
package dnsa_pkg;

  localparam int BYTE_W   = 8;
  localparam int POS_W    = 16;
  localparam int ADDR_W   = 32;
  localparam int CAP_W    = 16;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int LABEL_W  = 6;
  localparam int ANS_IDX_W = 4;

  localparam logic [POS_W-1:0]   POS_MAX        = 16'hFFFF;
  localparam logic [CAP_W-1:0]   CAPACITY_RESET = 16'd512;
  localparam logic [BYTE_W-1:0]  LABEL_MAX      = 8'd63;
  localparam logic [BYTE_W-1:0]  TTL_SECONDS    = 8'd60;
  localparam logic [POS_W:0]     ANSWER_LEN     = 17'd16;
  localparam logic [ANS_IDX_W-1:0] ANS_LAST_IDX = 4'd15;

  // header offsets that get checked or patched
  localparam logic [POS_W-1:0] POS_FLAGS_HI = 16'd2;
  localparam logic [POS_W-1:0] POS_FLAGS_LO = 16'd3;
  localparam logic [POS_W-1:0] POS_QD_HI    = 16'd4;
  localparam logic [POS_W-1:0] POS_QD_LO    = 16'd5;
  localparam logic [POS_W-1:0] POS_AN_LO    = 16'd7;
  localparam logic [POS_W-1:0] POS_HDR_END  = 16'd11;

  localparam logic [BYTE_W-1:0] FLAGS_REPLY = 8'h84;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ANSWER_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_LIMIT    = 2'd1;

  // reply status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TRUNCATED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_HEADER    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LABEL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TYPE      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd5;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LEN,
    PH_LABEL,
    PH_TYPE,
    PH_DONE
  } phase_t;

  // work left over from one request beat
  typedef struct packed {
    logic                echo_vld;
    logic [BYTE_W-1:0]   echo_byte;
    logic                fin_vld;
    logic [STATUS_W-1:0] fin_status;
  } desc_t;

  // answer record: name pointer, type A, class IN, ttl, rdlength, address
  function automatic logic [BYTE_W-1:0] answer_byte(input logic [ANS_IDX_W-1:0] idx,
                                                    input logic [ADDR_W-1:0]    addr);
    logic [BYTE_W-1:0] b;
    b = 8'h00;
    unique case (idx)
      4'd0:  b = 8'hC0;
      4'd1:  b = 8'h0C;
      4'd3:  b = 8'h01;
      4'd5:  b = 8'h01;
      4'd9:  b = TTL_SECONDS;
      4'd11: b = 8'h04;
      4'd12: b = addr[31:24];
      4'd13: b = addr[23:16];
      4'd14: b = addr[15:8];
      4'd15: b = addr[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* hdl/dnsa_ifs.sv */
// dnsa_ifs: valid/ready channel interfaces for request, reply and
// configuration. Depends on dnsa_pkg.
interface dnsa_req_if;
  import dnsa_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] request_byte;
  logic              request_last;
  modport source (output valid, request_byte, request_last, input ready);
  modport sink   (input valid, request_byte, request_last, output ready);
endinterface

interface dnsa_rep_if;
  import dnsa_pkg::*;
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   reply_byte;
  logic                reply_last;
  logic [STATUS_W-1:0] reply_status;
  modport source (output valid, reply_byte, reply_last, reply_status, input ready);
  modport sink   (input valid, reply_byte, reply_last, reply_status, output ready);
endinterface

interface dnsa_cfg_if;
  import dnsa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [ADDR_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/dnsa_cfg_regs.sv */
// dnsa_cfg_regs: answer address and reply limit registers.
// Depends on dnsa_pkg and dnsa_cfg_if.
module dnsa_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  dnsa_cfg_if.sink                     cfg_if,
  output logic [dnsa_pkg::ADDR_W-1:0]  answer_address,
  output logic [dnsa_pkg::CAP_W-1:0]   reply_limit
);
  import dnsa_pkg::*;

  logic [ADDR_W-1:0] addr_r;
  logic [CAP_W-1:0]  cap_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      cap_r  <= CAPACITY_RESET;
    end else if (cfg_if.valid) begin
      // unknown indexes fall through
      if (cfg_if.index == CFG_ANSWER_ADDRESS) begin
        addr_r <= cfg_if.data;
      end else if (cfg_if.index == CFG_REPLY_LIMIT) begin
        cap_r <= cfg_if.data[CAP_W-1:0];
      end
    end
  end

  assign answer_address = addr_r;
  assign reply_limit    = cap_r;

endmodule

/* hdl/dnsa_parser.sv */
// dnsa_parser: per-beat query parse state and echo/final decision.
// Depends on dnsa_pkg and dnsa_req_if.
module dnsa_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  dnsa_req_if.sink                    in_if,
  input  logic                        take,
  input  logic [dnsa_pkg::CAP_W-1:0]  reply_limit,
  output dnsa_pkg::desc_t             desc,
  output logic                        desc_vld
);
  import dnsa_pkg::*;

  logic [POS_W-1:0]    pos_r, pos_nxt;
  phase_t              phase_r, phase_step, phase_nxt;
  logic [LABEL_W-1:0]  lrem_r, lrem_step, lrem_nxt;
  logic [1:0]          tail_r, tail_step, tail_nxt;
  logic [STATUS_W-1:0] err_r, err_step, err_nxt;
  logic [POS_W-1:0]    qend_r, qend_step, qend_nxt;
  logic                echo;
  logic [BYTE_W-1:0]   eb;
  logic [BYTE_W-1:0]   b;
  logic                acc;
  logic                live;
  logic [LABEL_W-1:0]  lrem_dec;
  logic [STATUS_W-1:0] status;

  assign in_if.ready = take;
  assign acc  = in_if.valid & take;
  assign b    = in_if.request_byte;
  assign live = (pos_r != POS_MAX) && (err_r == ST_OK);
  assign lrem_dec = lrem_r - 1'b1;

  // next phase
  always_comb begin
    phase_step = phase_r;
    if (live) begin
      unique case (phase_r)
        PH_HEADER: if (pos_r >= POS_HDR_END) phase_step = PH_LEN;
        PH_LEN: begin
          if (b == '0) phase_step = PH_TYPE;
          else if (b <= LABEL_MAX) phase_step = PH_LABEL;
        end
        PH_LABEL: if (lrem_dec == '0) phase_step = PH_LEN;
        PH_TYPE: begin
          if (b == {7'd0, tail_r[0]} && tail_r == 2'd3) phase_step = PH_DONE;
        end
        PH_DONE: phase_step = PH_DONE;
        default: phase_step = phase_r;
      endcase
    end
  end

  // echo beat, error and field updates
  always_comb begin
    echo      = 1'b0;
    eb        = b;
    err_step  = err_r;
    lrem_step = lrem_r;
    tail_step = tail_r;
    qend_step = qend_r;
    if (pos_r == POS_MAX) begin
      err_step = ST_TOO_LARGE;
    end else if (err_r == ST_OK) begin
      unique case (phase_r)
        PH_HEADER: begin
          echo = 1'b1;
          priority if (pos_r == POS_FLAGS_HI) begin
            if (b[7:3] != '0) begin
              err_step = ST_HEADER;
              echo     = 1'b0;
            end
            eb = FLAGS_REPLY | {7'd0, b[0]};
          end else if (pos_r == POS_QD_HI) begin
            if (b != 8'd0) begin
              err_step = ST_HEADER;
              echo     = 1'b0;
            end
            eb = 8'd0;
          end else if (pos_r == POS_QD_LO) begin
            if (b != 8'd1) begin
              err_step = ST_HEADER;
              echo     = 1'b0;
            end
            eb = 8'd1;
          end else if (pos_r == POS_AN_LO) begin
            eb = 8'd1;
          end else if (pos_r >= POS_FLAGS_LO) begin
            eb = 8'd0;
          end else begin
            eb = b;
          end
        end
        PH_LEN: begin
          if (b == '0) begin
            tail_step = 2'd0;
            echo      = 1'b1;
          end else if (b > LABEL_MAX) begin
            err_step = ST_LABEL;
          end else begin
            lrem_step = b[LABEL_W-1:0];
            echo      = 1'b1;
          end
        end
        PH_LABEL: begin
          echo      = 1'b1;
          lrem_step = lrem_dec;
        end
        PH_TYPE: begin
          if (b != {7'd0, tail_r[0]}) begin
            err_step = ST_TYPE;
          end else begin
            echo = 1'b1;
            if (tail_r == 2'd3) qend_step = pos_r + 1'b1;
            else tail_step = tail_r + 1'b1;
          end
        end
        PH_DONE: echo = 1'b0;
        default: echo = 1'b0;
      endcase
    end
  end

  // status of the final beat, from the post-step state
  always_comb begin
    status = err_step;
    if (err_step == ST_OK) begin
      unique case (phase_step)
        PH_HEADER: status = ST_HEADER;
        PH_LEN:    status = ST_LABEL;
        PH_LABEL:  status = ST_LABEL;
        PH_TYPE:   status = ST_TYPE;
        PH_DONE: begin
          if ({1'b0, qend_step} + ANSWER_LEN > {1'b0, reply_limit})
            status = ST_TRUNCATED;
          else
            status = ST_OK;
        end
        default: status = ST_OK;
      endcase
    end
  end

  // the final request beat puts everything back to the start
  always_comb begin
    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    lrem_nxt  = lrem_r;
    tail_nxt  = tail_r;
    err_nxt   = err_r;
    qend_nxt  = qend_r;
    if (acc) begin
      if (in_if.request_last) begin
        pos_nxt   = '0;
        phase_nxt = PH_HEADER;
        lrem_nxt  = '0;
        tail_nxt  = '0;
        err_nxt   = ST_OK;
        qend_nxt  = '0;
      end else begin
        pos_nxt   = (pos_r != POS_MAX) ? pos_r + 1'b1 : pos_r;
        phase_nxt = phase_step;
        lrem_nxt  = lrem_step;
        tail_nxt  = tail_step;
        err_nxt   = err_step;
        qend_nxt  = qend_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= PH_HEADER;
      lrem_r  <= '0;
      tail_r  <= '0;
      err_r   <= ST_OK;
      qend_r  <= '0;
    end else begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      lrem_r  <= lrem_nxt;
      tail_r  <= tail_nxt;
      err_r   <= err_nxt;
      qend_r  <= qend_nxt;
    end
  end

  assign desc.echo_vld   = echo;
  assign desc.echo_byte  = eb;
  assign desc.fin_vld    = in_if.request_last;
  assign desc.fin_status = status;
  assign desc_vld        = acc & (echo | in_if.request_last);

endmodule

/* hdl/dnsa_emitter.sv */
// dnsa_emitter: holds one beat's pending work and plays it out through the
// reply output register, including the 16-beat answer record.
// Depends on dnsa_pkg and dnsa_rep_if.
module dnsa_emitter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dnsa_pkg::desc_t              desc,
  input  logic                         desc_vld,
  input  logic [dnsa_pkg::ADDR_W-1:0]  answer_address,
  output logic                         take,
  dnsa_rep_if.source                   out_if
);
  import dnsa_pkg::*;

  desc_t                desc_r;
  logic                 desc_vld_r, desc_vld_nxt;
  logic                 echo_done_r, echo_done_nxt;
  logic [ANS_IDX_W-1:0] idx_r, idx_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic [BYTE_W-1:0]    out_byte_r;
  logic                 out_last_r;
  logic [STATUS_W-1:0]  out_status_r;

  logic                 out_free;
  logic                 load;
  logic                 has_echo;
  logic                 pop;
  logic [BYTE_W-1:0]    item_byte;
  logic                 item_last;
  logic [STATUS_W-1:0]  item_status;
  logic                 item_final;

  assign out_free = !out_vld_r || out_if.ready;
  assign load     = desc_vld_r && out_free;
  assign has_echo = desc_r.echo_vld && !echo_done_r;

  // pick the next beat out of the held work
  always_comb begin
    item_byte   = '0;
    item_last   = 1'b0;
    item_status = ST_OK;
    item_final  = 1'b0;
    if (has_echo) begin
      item_byte  = desc_r.echo_byte;
      item_final = !desc_r.fin_vld;
    end else if (desc_r.fin_status != ST_OK) begin
      item_last   = 1'b1;
      item_status = desc_r.fin_status;
      item_final  = 1'b1;
    end else begin
      item_byte  = answer_byte(idx_r, answer_address);
      item_last  = (idx_r == ANS_LAST_IDX);
      item_final = (idx_r == ANS_LAST_IDX);
    end
  end

  assign pop  = load && item_final;
  assign take = !desc_vld_r || pop;

  always_comb begin
    desc_vld_nxt  = take ? desc_vld : desc_vld_r;
    echo_done_nxt = echo_done_r;
    idx_nxt       = idx_r;
    if (pop) begin
      echo_done_nxt = 1'b0;
      idx_nxt       = '0;
    end else if (load) begin
      if (has_echo) echo_done_nxt = 1'b1;
      else idx_nxt = idx_r + 1'b1;
    end
    out_vld_nxt = load ? 1'b1 : (out_if.ready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_vld_r  <= 1'b0;
      echo_done_r <= 1'b0;
      idx_r       <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      desc_vld_r  <= desc_vld_nxt;
      echo_done_r <= echo_done_nxt;
      idx_r       <= idx_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) desc_r <= desc;
    if (load) begin
      out_byte_r   <= item_byte;
      out_last_r   <= item_last;
      out_status_r <= item_status;
    end
  end

  assign out_if.valid        = out_vld_r;
  assign out_if.reply_byte   = out_byte_r;
  assign out_if.reply_last   = out_last_r;
  assign out_if.reply_status = out_status_r;

endmodule

/* hdl/dns_a_query_responder_unit.sv */
// Takes one query byte per cycle and answers with one reply beat per cycle
// when not stalled. A byte of the header or question gives at most one echo
// beat, so with the reply side ready a query streams through at one byte per
// cycle; the final byte of a good query expands into the 16-beat answer
// record, and the request side then stalls while those beats, plus the echo
// beat when that final byte is echoed as well, leave the single reply output
// register. An error final gives one beat, plus the echo beat when that byte
// is echoed, and the request side waits at most until they leave. A byte
// passes the held work register desc_r, then the reply output register. Echoed
// beats are speculative: a consumer must drop them when the final beat carries
// a nonzero status. Register writes are taken at any time but belong in idle
// periods. Depends on dnsa_pkg, dnsa_ifs and the dnsa_* submodules.
module dns_a_query_responder_unit (
  input  logic        clk,
  input  logic        rst_n,
  dnsa_req_if.sink    in_if,
  dnsa_rep_if.source  out_if,
  dnsa_cfg_if.sink    cfg_if
);
  import dnsa_pkg::*;

  logic [ADDR_W-1:0] answer_address;
  logic [CAP_W-1:0]  reply_limit;
  desc_t             desc;
  logic              desc_vld;
  logic              take;

  dnsa_cfg_regs u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_if         (cfg_if),
    .answer_address (answer_address),
    .reply_limit    (reply_limit)
  );

  dnsa_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_if          (in_if),
    .take           (take),
    .reply_limit    (reply_limit),
    .desc           (desc),
    .desc_vld       (desc_vld)
  );

  dnsa_emitter u_emitter (
    .clk            (clk),
    .rst_n          (rst_n),
    .desc           (desc),
    .desc_vld       (desc_vld),
    .answer_address (answer_address),
    .take           (take),
    .out_if         (out_if)
  );

endmodule
